/* hw/rtl/x86enc_pkg.sv */
// Package for the x86-64 instruction encoder: form codes, encoding constants
// and the stage-to-stage structs. No dependencies.
package x86enc_pkg;

  typedef enum logic [2:0] {
    FORM_RR     = 3'd0,
    FORM_RI8    = 3'd1,
    FORM_RI32   = 3'd2,
    FORM_MEM    = 3'd3,
    FORM_MEM_D8 = 3'd4,
    FORM_MEM_D32 = 3'd5,
    FORM_ACC    = 3'd6,
    FORM_SINGLE = 3'd7
  } form_t;

  localparam logic [3:0] REX_HI      = 4'h4;   // upper nibble of REX (0x40)
  localparam logic [7:0] SIB_RSP     = 8'h24;  // SIB for rsp/r12 base
  localparam logic [5:0] OPC_IMM_GRP = 6'h20;  // 0x81 / 0x83 group
  localparam logic [2:0] RM_SP       = 3'd4;
  localparam logic [2:0] RM_BP       = 3'd5;

  localparam logic [1:0] MOD_IND = 2'd0;
  localparam logic [1:0] MOD_D8  = 2'd1;
  localparam logic [1:0] MOD_D32 = 2'd2;
  localparam logic [1:0] MOD_REG = 2'd3;

  // Trailing field length in bytes: 0, 1 or 4.
  localparam logic [2:0] IMM_NONE = 3'd0;
  localparam logic [2:0] IMM_B8   = 3'd1;
  localparam logic [2:0] IMM_B32  = 3'd4;

  typedef struct packed {
    logic        rex_en;
    logic [7:0]  rex;
    logic [7:0]  opc;
    logic        modrm_en;
    logic [7:0]  modrm;
    logic        sib_en;
    logic [2:0]  imm_len;
    logic [31:0] imm;
  } dec_t;

  typedef struct packed {
    logic [31:0] head;      // prefix, opcode, ModRM, SIB packed low first
    logic [2:0]  head_cnt;  // 1..4
    logic [2:0]  imm_len;
    logic [31:0] imm;
  } head_t;

endpackage

/* hw/rtl/x86enc_decode.sv */
// Stage 1: field decode into REX, opcode, ModRM, SIB and trailing field.
// Depends on x86enc_pkg.
module x86enc_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [2:0]          func,
  input  logic                wide,
  input  logic [3:0]          rm_register,
  input  logic [3:0]          reg_register,
  input  logic [7:0]          opcode_value,
  input  logic                load_direction,
  input  logic [31:0]         immediate,
  output logic                vld_r,
  output x86enc_pkg::dec_t    dec_r
);

  x86enc_pkg::dec_t dec_nxt;
  logic             rex_w;
  logic             rex_r;
  logic             rex_b;
  logic [1:0]       mod;
  logic [2:0]       modrm_reg;

  always_comb begin
    dec_nxt   = '0;
    rex_w     = wide;
    rex_r     = reg_register[3];
    rex_b     = rm_register[3];
    mod       = x86enc_pkg::MOD_REG;
    modrm_reg = reg_register[2:0];
    dec_nxt.modrm_en = 1'b1;
    dec_nxt.imm_len  = x86enc_pkg::IMM_NONE;
    dec_nxt.imm      = immediate;
    dec_nxt.opc      = {opcode_value[5:0], 1'b0, 1'b1};
    unique case (x86enc_pkg::form_t'(func)) inside
      x86enc_pkg::FORM_RR: begin
      end
      x86enc_pkg::FORM_RI8: begin
        rex_r            = 1'b0;
        modrm_reg        = opcode_value[2:0];
        dec_nxt.opc      = {x86enc_pkg::OPC_IMM_GRP, 1'b1, 1'b1};
        dec_nxt.imm_len  = x86enc_pkg::IMM_B8;
      end
      x86enc_pkg::FORM_RI32: begin
        rex_r            = 1'b0;
        modrm_reg        = opcode_value[2:0];
        dec_nxt.opc      = {x86enc_pkg::OPC_IMM_GRP, 1'b0, 1'b1};
        dec_nxt.imm_len  = x86enc_pkg::IMM_B32;
      end
      x86enc_pkg::FORM_MEM, x86enc_pkg::FORM_MEM_D8, x86enc_pkg::FORM_MEM_D32: begin
        dec_nxt.opc    = {opcode_value[5:0], load_direction, 1'b1};
        dec_nxt.sib_en = (rm_register[2:0] == x86enc_pkg::RM_SP);
        if (func == x86enc_pkg::FORM_MEM_D32) begin
          mod             = x86enc_pkg::MOD_D32;
          dec_nxt.imm_len = x86enc_pkg::IMM_B32;
        end else if (func == x86enc_pkg::FORM_MEM_D8) begin
          mod             = x86enc_pkg::MOD_D8;
          dec_nxt.imm_len = x86enc_pkg::IMM_B8;
        end else if (rm_register[2:0] == x86enc_pkg::RM_BP) begin
          // rbp/r13 base has no plain indirect mode: use disp8 of zero
          mod             = x86enc_pkg::MOD_D8;
          dec_nxt.imm_len = x86enc_pkg::IMM_B8;
          dec_nxt.imm     = '0;
        end else begin
          mod             = x86enc_pkg::MOD_IND;
        end
      end
      x86enc_pkg::FORM_ACC: begin
        rex_r            = 1'b0;
        rex_b            = 1'b0;
        dec_nxt.modrm_en = 1'b0;
        dec_nxt.imm_len  = x86enc_pkg::IMM_B32;
      end
      x86enc_pkg::FORM_SINGLE: begin
        rex_w            = 1'b0;
        rex_r            = 1'b0;
        dec_nxt.modrm_en = 1'b0;
        dec_nxt.opc      = opcode_value | {5'd0, rm_register[2:0]};
      end
      default: begin
      end
    endcase
    dec_nxt.rex    = {x86enc_pkg::REX_HI, rex_w, rex_r, 1'b0, rex_b};
    dec_nxt.rex_en = rex_w | rex_r | rex_b;
    dec_nxt.modrm  = {mod, modrm_reg, rm_register[2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
  end

endmodule

/* hw/rtl/x86enc_pack.sv */
// Stage 2: packs REX, opcode, ModRM and SIB into a head word with its count.
// Depends on x86enc_pkg.
module x86enc_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld,
  input  x86enc_pkg::dec_t    dec,
  output logic                vld_r,
  output x86enc_pkg::head_t   hd_r
);

  x86enc_pkg::head_t hd_nxt;
  logic [31:0]       h0;
  logic [31:0]       h1;
  logic [2:0]        c0;
  logic [2:0]        c1;

  always_comb begin
    if (dec.rex_en) begin
      h0 = {16'd0, dec.opc, dec.rex};
      c0 = 3'd2;
    end else begin
      h0 = {24'd0, dec.opc};
      c0 = 3'd1;
    end
    if (dec.modrm_en) begin
      h1 = h0 | ({24'd0, dec.modrm} << {c0[1:0], 3'b000});
      c1 = c0 + 3'd1;
    end else begin
      h1 = h0;
      c1 = c0;
    end
    hd_nxt.imm_len = dec.imm_len;
    hd_nxt.imm     = dec.imm;
    if (dec.sib_en) begin
      hd_nxt.head     = h1 | ({24'd0, x86enc_pkg::SIB_RSP} << {c1[1:0], 3'b000});
      hd_nxt.head_cnt = c1 + 3'd1;
    end else begin
      hd_nxt.head     = h1;
      hd_nxt.head_cnt = c1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    hd_r <= hd_nxt;
  end

endmodule

/* hw/rtl/x86enc_merge.sv */
// Stage 3: appends the immediate/displacement after the head, output register.
// Depends on x86enc_pkg.
module x86enc_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld,
  input  x86enc_pkg::head_t   hd,
  output logic                out_valid,
  output logic [63:0]         out_code_bytes,
  output logic [3:0]          out_byte_count
);

  logic [31:0] imm_m;
  logic [63:0] code_nxt;
  logic [3:0]  cnt_nxt;
  logic        valid_r;
  logic [63:0] code_r;
  logic [3:0]  cnt_r;

  always_comb begin
    case (hd.imm_len)
      x86enc_pkg::IMM_B8:  imm_m = {24'd0, hd.imm[7:0]};
      x86enc_pkg::IMM_B32: imm_m = hd.imm;
      default:             imm_m = '0;
    endcase
    code_nxt = {32'd0, hd.head} | ({32'd0, imm_m} << {hd.head_cnt, 3'b000});
    cnt_nxt  = {1'b0, hd.head_cnt} + {1'b0, hd.imm_len};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_valid      = valid_r;
  assign out_code_bytes = code_r;
  assign out_byte_count = cnt_r;

endmodule

/* hw/rtl/x86_64_instruction_encoder_core.sv */
// Channel  | Ports                                             | Handshake
// ---------+---------------------------------------------------+---------------------------
// input    | in_func in_wide in_rm_register in_reg_register    | start & !busy
//          | in_opcode_value in_load_direction in_immediate    |
// result   | out_code_bytes out_byte_count                     | out_valid, one-cycle strobe
//
// One instruction per cycle; busy stays low. Each instruction passes decode,
// head pack and immediate merge, each ending in a register; out_valid is the
// valid bit of the merge register. Synchronous reset clears the valid bits of
// all stages; nothing else is kept. The receiver cannot stall, so the pipeline
// advances every cycle.
// Depends on x86enc_pkg, x86enc_decode, x86enc_pack, x86enc_merge.
module x86_64_instruction_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic        in_wide,
  input  logic [3:0]  in_rm_register,
  input  logic [3:0]  in_reg_register,
  input  logic [7:0]  in_opcode_value,
  input  logic        in_load_direction,
  input  logic [31:0] in_immediate,
  output logic        out_valid,
  output logic [63:0] out_code_bytes,
  output logic [3:0]  out_byte_count
);

  logic              s1_vld;
  logic              s2_vld;
  x86enc_pkg::dec_t  s1_dec;
  x86enc_pkg::head_t s2_hd;

  assign busy = 1'b0;

  x86enc_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (start & ~busy),
    .func           (in_func),
    .wide           (in_wide),
    .rm_register    (in_rm_register),
    .reg_register   (in_reg_register),
    .opcode_value   (in_opcode_value),
    .load_direction (in_load_direction),
    .immediate      (in_immediate),
    .vld_r          (s1_vld),
    .dec_r          (s1_dec)
  );

  x86enc_pack u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (s1_vld),
    .dec   (s1_dec),
    .vld_r (s2_vld),
    .hd_r  (s2_hd)
  );

  x86enc_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .vld            (s2_vld),
    .hd             (s2_hd),
    .out_valid      (out_valid),
    .out_code_bytes (out_code_bytes),
    .out_byte_count (out_byte_count)
  );

endmodule

/* hw/rtl/x86enc_checker.sv */
// Port-level checker for the encoder core, bound to the top level.
// Depends only on the ports of x86_64_instruction_encoder_core.
module x86enc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_code_bytes,
  input logic [3:0]  out_byte_count
);

  // the result strobe follows exactly the accepted transactions, delayed by the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
      |-> out_valid == $past(start && !busy, 3))
    else $error("result strobe does not match accepted transaction");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count >= 4'd1) && (out_byte_count <= 4'd8))
    else $error("byte count out of range");

  // when the count is at most four, the upper four bytes must be zero
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_count <= 4'd4) |-> out_code_bytes[63:32] == 32'd0)
    else $error("nonzero bytes beyond byte count");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("result strobe too soon after reset");

endmodule

bind x86_64_instruction_encoder_core x86enc_checker u_x86enc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_code_bytes (out_code_bytes),
  .out_byte_count (out_byte_count)
);

/* tb/x86_64_instruction_encoder_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for x86_64_instruction_encoder_core: a directed table, then
// random instructions, compared with typed or in-bench encodings. Depends on x86enc_pkg.
module x86_64_instruction_encoder_core_tb;

  localparam int RANDOM_INSTRS = 1600;
  localparam int STALL_LIMIT   = 500;
  localparam int DRAIN_CYCLES  = 8;
  localparam int NUM_DIRECTED  = 22;

  typedef struct {
    x86enc_pkg::form_t form;
    logic        wide;
    logic [3:0]  rm;
    logic [3:0]  rg;
    logic [7:0]  opc;
    logic        dir;
    logic [31:0] imm;
    logic        known;   // expected encoding typed into the table
    logic [63:0] bytes;
    logic [3:0]  count;
  } instr_row_t;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  count;
  } encoding_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic        in_wide;
  logic [3:0]  in_rm_register;
  logic [3:0]  in_reg_register;
  logic [7:0]  in_opcode_value;
  logic        in_load_direction;
  logic [31:0] in_immediate;
  logic        out_valid;
  logic [63:0] out_code_bytes;
  logic [3:0]  out_byte_count;

  // typed expectation travels with the pins of a directed row
  logic        row_known;
  logic [63:0] row_bytes;
  logic [3:0]  row_count;

  encoding_t   pending_encodings[$];
  encoding_t   want;
  logic        took_instr;
  int          stall_cycles;
  int          mismatches;
  int          instrs_taken;
  int          results_seen;
  int          form_hits[8];

  instr_row_t  directed_rows[NUM_DIRECTED];

  x86_64_instruction_encoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_wide           (in_wide),
    .in_rm_register    (in_rm_register),
    .in_reg_register   (in_reg_register),
    .in_opcode_value   (in_opcode_value),
    .in_load_direction (in_load_direction),
    .in_immediate      (in_immediate),
    .out_valid         (out_valid),
    .out_code_bytes    (out_code_bytes),
    .out_byte_count    (out_byte_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic encoding_t encode_instr(x86enc_pkg::form_t f, logic w,
                                             logic [3:0] rm, logic [3:0] rg,
                                             logic [7:0] opc, logic dir,
                                             logic [31:0] imm);
    logic [7:0]  seq [0:7];
    int          n;
    int          tail_len;
    logic [31:0] tail;
    logic        rex_w, rex_r, rex_b;
    logic        has_modrm, has_sib;
    logic [1:0]  md;
    logic [2:0]  mreg;
    logic [7:0]  opbyte;
    encoding_t   enc;

    rex_w = w;
    rex_r = rg[3];
    rex_b = rm[3];
    has_modrm = 1'b1;
    has_sib = 1'b0;
    md = x86enc_pkg::MOD_REG;
    mreg = rg[2:0];
    tail = imm;
    tail_len = 0;
    opbyte = {opc[5:0], 1'b0, 1'b1};
    case (f) inside
      x86enc_pkg::FORM_RR: ;
      x86enc_pkg::FORM_RI8, x86enc_pkg::FORM_RI32: begin
        rex_r = 1'b0;
        mreg = opc[2:0];
        opbyte = {x86enc_pkg::OPC_IMM_GRP, f == x86enc_pkg::FORM_RI8, 1'b1};
        tail_len = (f == x86enc_pkg::FORM_RI8) ? 1 : 4;
      end
      x86enc_pkg::FORM_MEM, x86enc_pkg::FORM_MEM_D8, x86enc_pkg::FORM_MEM_D32: begin
        opbyte = {opc[5:0], dir, 1'b1};
        has_sib = (rm[2:0] == x86enc_pkg::RM_SP);
        if (f == x86enc_pkg::FORM_MEM) begin
          // frame-pointer base cannot be encoded bare: use a zero disp8
          md = (rm[2:0] == x86enc_pkg::RM_BP) ? x86enc_pkg::MOD_D8 : x86enc_pkg::MOD_IND;
          tail = '0;
        end else begin
          md = (f == x86enc_pkg::FORM_MEM_D8) ? x86enc_pkg::MOD_D8 : x86enc_pkg::MOD_D32;
        end
        tail_len = (md == x86enc_pkg::MOD_D8) ? 1 : (md == x86enc_pkg::MOD_D32) ? 4 : 0;
      end
      x86enc_pkg::FORM_ACC: begin
        rex_r = 1'b0;
        rex_b = 1'b0;
        has_modrm = 1'b0;
        tail_len = 4;
      end
      default: begin
        rex_w = 1'b0;
        rex_r = 1'b0;
        has_modrm = 1'b0;
        opbyte = opc | {5'd0, rm[2:0]};
      end
    endcase

    n = 0;
    if (rex_w | rex_r | rex_b) begin
      seq[n] = {x86enc_pkg::REX_HI, rex_w, rex_r, 1'b0, rex_b};
      n = n + 1;
    end
    seq[n] = opbyte;
    n = n + 1;
    if (has_modrm) begin
      seq[n] = {md, mreg, rm[2:0]};
      n = n + 1;
    end
    if (has_sib) begin
      seq[n] = x86enc_pkg::SIB_RSP;
      n = n + 1;
    end
    for (int k = 0; k < tail_len; k++) begin
      seq[n] = tail[8*k +: 8];
      n = n + 1;
    end

    enc.bytes = '0;
    for (int k = 0; k < n; k++) enc.bytes[8*k +: 8] = seq[k];
    enc.count = 4'(n);
    return enc;
  endfunction

  function automatic logic [31:0] pick_immediate();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'(8'h7F + $urandom_range(1));
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_row_t random_row();
    instr_row_t r;
    r.form  = x86enc_pkg::form_t'($urandom_range(7));
    r.wide  = 1'($urandom_range(1));
    r.rm    = 4'($urandom_range(15));
    r.rg    = 4'($urandom_range(15));
    r.opc   = 8'($urandom_range(255));
    r.dir   = 1'($urandom_range(1));
    r.imm   = pick_immediate();
    r.known = 1'b0;
    r.bytes = '0;
    r.count = '0;
    return r;
  endfunction

  // Puts one instruction on the pins and returns at the falling edge after it
  // was taken. Idle cycles in front carry junk on the pins with start low.
  task automatic send_instr(instr_row_t r, bit may_idle);
    instr_row_t junk;
    while (may_idle && $urandom_range(99) < 22) begin
      junk = random_row();
      start <= 1'b0;
      in_func <= junk.form;
      in_rm_register <= junk.rm;
      in_immediate <= junk.imm;
      @(negedge clk);
    end
    start <= 1'b1;
    in_func <= r.form;
    in_wide <= r.wide;
    in_rm_register <= r.rm;
    in_reg_register <= r.rg;
    in_opcode_value <= r.opc;
    in_load_direction <= r.dir;
    in_immediate <= r.imm;
    row_known <= r.known;
    row_bytes <= r.bytes;
    row_count <= r.count;
    do @(negedge clk); while (!took_instr);
  endtask

  // Result check first: as every stage is registered, the result leaving in
  // this cycle always belongs to an older transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      took_instr = 1'b0;
      stall_cycles = 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (pending_encodings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: bytes %h count %0d",
                     out_code_bytes, out_byte_count);
        end else begin
          want = pending_encodings.pop_front();
          if (out_code_bytes !== want.bytes || out_byte_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch %0d: bytes exp %h got %h, count exp %0d got %0d",
                       results_seen, want.bytes, out_code_bytes, want.count, out_byte_count);
          end
        end
      end
      took_instr = start && !busy;
      if (took_instr) begin
        instrs_taken++;
        form_hits[in_func]++;
        if (row_known) begin
          want.bytes = row_bytes;
          want.count = row_count;
        end else begin
          want = encode_instr(x86enc_pkg::form_t'(in_func), in_wide, in_rm_register,
                              in_reg_register, in_opcode_value, in_load_direction,
                              in_immediate);
        end
        pending_encodings.push_back(want);
      end
      if (took_instr || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = '0;
    in_wide = 1'b0;
    in_rm_register = '0;
    in_reg_register = '0;
    in_opcode_value = '0;
    in_load_direction = 1'b0;
    in_immediate = '0;
    row_known = 1'b0;
    row_bytes = '0;
    row_count = '0;
    mismatches = 0;
    instrs_taken = 0;
    results_seen = 0;
    foreach (form_hits[k]) form_hits[k] = 0;

    directed_rows = '{
      '{x86enc_pkg::FORM_RR,      1'b0, 4'd0,  4'd0,  8'h00, 1'b0, 32'h0,
        1'b1, 64'hC001, 4'd2},
      '{x86enc_pkg::FORM_RR,      1'b1, 4'd15, 4'd15, 8'hFF, 1'b1, 32'hFFFF_FFFF,
        1'b1, 64'hFF_FD4D, 4'd3},
      '{x86enc_pkg::FORM_RR,      1'b0, 4'd8,  4'd3,  8'h00, 1'b0, 32'h0,
        1'b0, 64'h0, 4'd0},
      // extension forms: reg_register must not leak into ModRM or REX.R
      '{x86enc_pkg::FORM_RI8,     1'b0, 4'd0,  4'd15, 8'hFF, 1'b0, 32'h0000_0080,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_RI8,     1'b1, 4'd9,  4'd8,  8'h07, 1'b1, 32'hFFFF_FF7F,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_RI32,    1'b1, 4'd15, 4'd0,  8'hFF, 1'b0, 32'hFFFF_FFFF,
        1'b1, 64'h00FF_FFFF_FFFF_8149, 4'd7},
      '{x86enc_pkg::FORM_RI32,    1'b0, 4'd0,  4'd0,  8'h00, 1'b0, 32'h0,
        1'b1, 64'hC081, 4'd6},
      '{x86enc_pkg::FORM_MEM,     1'b0, 4'd0,  4'd2,  8'h22, 1'b1, 32'hFFFF_FFFF,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM,     1'b0, 4'd4,  4'd1,  8'h02, 1'b0, 32'h0,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM,     1'b0, 4'd5,  4'd6,  8'h01, 1'b1, 32'hA5A5_A5A5,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM,     1'b1, 4'd13, 4'd9,  8'h3F, 1'b0, 32'h0,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM,     1'b1, 4'd12, 4'd15, 8'hC0, 1'b1, 32'h0,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM_D8,  1'b0, 4'd5,  4'd0,  8'h00, 1'b0, 32'hFFFF_FF80,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM_D8,  1'b1, 4'd12, 4'd7,  8'h0A, 1'b1, 32'h0000_007F,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM_D8,  1'b0, 4'd4,  4'd7,  8'h0A, 1'b0, 32'h0,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_MEM_D32, 1'b1, 4'd12, 4'd15, 8'h3F, 1'b1, 32'hFFFF_FFFF,
        1'b1, 64'hFFFF_FFFF_24BC_FF4D, 4'd8},
      '{x86enc_pkg::FORM_MEM_D32, 1'b0, 4'd5,  4'd3,  8'h22, 1'b0, 32'h1234_5678,
        1'b0, 64'h0, 4'd0},
      // accumulator form ignores both registers
      '{x86enc_pkg::FORM_ACC,     1'b0, 4'd15, 4'd15, 8'h01, 1'b1, 32'hFFFF_FFFF,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_ACC,     1'b1, 4'd0,  4'd0,  8'hC1, 1'b0, 32'h0,
        1'b0, 64'h0, 4'd0},
      '{x86enc_pkg::FORM_SINGLE,  1'b1, 4'd0,  4'd15, 8'h50, 1'b1, 32'hFFFF_FFFF,
        1'b1, 64'h50, 4'd1},
      '{x86enc_pkg::FORM_SINGLE,  1'b0, 4'd15, 4'd0,  8'h58, 1'b0, 32'h0,
        1'b1, 64'h5F41, 4'd2},
      '{x86enc_pkg::FORM_SINGLE,  1'b1, 4'd8,  4'd8,  8'hFF, 1'b0, 32'h0,
        1'b0, 64'h0, 4'd0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) send_instr(directed_rows[k], 1'b1);
    // a long back-to-back run in the middle of the random part
    for (int k = 0; k < RANDOM_INSTRS; k++) send_instr(random_row(), !(k >= 500 && k < 800));
    start <= 1'b0;
    row_known <= 1'b0;

    while (pending_encodings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_encodings.size();

    $display("encoded %0d instructions (%0d from the table), %0d results checked",
             instrs_taken, NUM_DIRECTED, results_seen);
    $display("per form rr/ri8/ri32/mem/d8/d32/acc/single: %0d %0d %0d %0d %0d %0d %0d %0d",
             form_hits[0], form_hits[1], form_hits[2], form_hits[3],
             form_hits[4], form_hits[5], form_hits[6], form_hits[7]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
